// ===== hw/rtl/bme_pkg.sv =====
package bme_pkg;

    // Block sizing.
    localparam int SIGNALS     = 8;
    localparam int CELLS       = 1024;
    localparam int FLOW_ID     = 0;
    localparam int LEAK_ID     = 1;
    localparam int PRESSURE_ID = 2;
    localparam int SCALE       = 60;

    // Field widths.
    localparam int TIME_W      = 48;
    localparam int VALUE_W     = 32;
    localparam int WIDTH_W     = 32;
    localparam int SUM_W       = 64;
    localparam int CNT_W       = 48;
    localparam int SIG_W       = 3;
    localparam int SRC_W       = 8;
    localparam int STATUS_W    = 3;
    localparam int BUCKET_W    = 10;
    localparam int CELLS_CFG_W = 11;
    localparam int MASK_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 48;

    // Quotient is one bit wider than the bucket index so that CELLS itself fits.
    localparam int QUOT_W      = $clog2(CELLS) + 1;
    localparam int QCNT_W      = $clog2(QUOT_W + 1);

    // Envelope store geometry. Seen flags are packed ROW_W to a memory row.
    localparam int DEPTH       = SIGNALS * CELLS;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int ROW_SEL_W   = 5;
    localparam int ROW_W       = 1 << ROW_SEL_W;
    localparam int ROW_ADDR_W  = ADDR_W - ROW_SEL_W;
    localparam int SEEN_ROWS   = 1 << ROW_ADDR_W;

    localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_DISABLED    = 3'd1,
        ST_OUT_PLOT    = 3'd2,
        ST_OUT_SESSION = 3'd3,
        ST_RANGE       = 3'd4
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_PLOT_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLOT_END   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_W   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOW_SRC   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAK_SRC   = 3'd6;

    typedef struct packed {
        logic              done;
        logic              over;
        logic [QUOT_W-1:0] quotient;
    } div_res_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } store_rd_t;

    typedef struct packed {
        logic                      en;
        logic [ADDR_W-1:0]         addr;
        logic signed [VALUE_W-1:0] low;
        logic signed [VALUE_W-1:0] high;
    } store_wr_t;

    typedef struct packed {
        logic                      seen;
        logic signed [VALUE_W-1:0] low;
        logic signed [VALUE_W-1:0] high;
    } store_rdata_t;

endpackage

// ===== hw/rtl/bme_divider.sv =====
module bme_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [bme_pkg::TIME_W-1:0]    dividend,
    input  logic [bme_pkg::WIDTH_W-1:0]   divisor,
    output bme_pkg::div_res_t             result
);
    import bme_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  over_reg, over_next;
    logic [QCNT_W-1:0]     cnt_reg, cnt_next;
    logic [WIDTH_W-1:0]    rem_reg, rem_next;
    logic [WIDTH_W-1:0]    dsr_reg, dsr_next;
    logic [QUOT_W-1:0]     shift_reg, shift_next;
    logic [QUOT_W-1:0]     quot_reg, quot_next;

    logic [WIDTH_W-1:0]    dsr_in;
    logic [WIDTH_W:0]      trial;
    logic                  fits;

    // The high part of the dividend is compared once; when it is already at or
    // above the divisor the quotient cannot fit and no iteration is needed.
    always_comb
    begin
        dsr_in     = (divisor == '0) ? WIDTH_W'(1) : divisor;
        trial      = {rem_reg, shift_reg[QUOT_W-1]};
        fits       = (trial >= {1'b0, dsr_reg});
        busy_next  = busy_reg;
        done_next  = 1'b0;
        over_next  = over_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        shift_next = shift_reg;
        quot_next  = quot_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            dsr_next   = dsr_in;
            over_next  = (dividend[TIME_W-1:QUOT_W] >=
                          (TIME_W-QUOT_W)'(dsr_in));
            rem_next   = dividend[QUOT_W+WIDTH_W-1:QUOT_W];
            shift_next = dividend[QUOT_W-1:0];
            quot_next  = '0;
            cnt_next   = QCNT_W'(QUOT_W);
        end
        else if (busy_reg)
        begin
            if (over_reg || cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                rem_next   = fits ? WIDTH_W'(trial - {1'b0, dsr_reg}) : trial[WIDTH_W-1:0];
                quot_next  = {quot_reg[QUOT_W-2:0], fits};
                shift_next = {shift_reg[QUOT_W-2:0], 1'b0};
                cnt_next   = cnt_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        over_reg  <= over_next;
        cnt_reg   <= cnt_next;
        rem_reg   <= rem_next;
        dsr_reg   <= dsr_next;
        shift_reg <= shift_next;
        quot_reg  <= quot_next;
    end

    assign result.done     = done_reg;
    assign result.over     = over_reg;
    assign result.quotient = quot_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held for more than one cycle");

    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !over_reg && !$rose(busy_reg)) |-> (rem_reg < dsr_reg))
        else $error("partial remainder reached the divisor");

endmodule

// ===== hw/rtl/bme_store.sv =====
module bme_store (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bme_pkg::store_rd_t      rd,
    input  bme_pkg::store_wr_t      wr,
    output bme_pkg::store_rdata_t   rdata,
    output logic                    busy
);
    import bme_pkg::*;

    logic [2*VALUE_W-1:0]  env_mem [DEPTH];
    logic [ROW_W-1:0]      seen_mem [SEEN_ROWS];

    logic [2*VALUE_W-1:0]  env_q_reg;
    logic [ROW_W-1:0]      row_q_reg;
    logic [ROW_SEL_W-1:0]  bit_q_reg;

    logic                  clear_reg, clear_next;
    logic [ROW_ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;

    // After reset every seen row is zeroed, one row a cycle.
    always_comb
    begin
        clear_next   = clear_reg;
        clr_cnt_next = clr_cnt_reg;
        if (clear_reg)
        begin
            clr_cnt_next = clr_cnt_reg + ROW_ADDR_W'(1);
            if (clr_cnt_reg == '1)
            begin
                clear_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg   <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else
        begin
            clear_reg   <= clear_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            env_q_reg <= env_mem[rd.addr];
            row_q_reg <= seen_mem[rd.addr[ADDR_W-1:ROW_SEL_W]];
            bit_q_reg <= rd.addr[ROW_SEL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            env_mem[wr.addr] <= {wr.high, wr.low};
        end
    end

    // The seen row was fetched by the read that precedes every write.
    always_ff @(posedge clk)
    begin
        if (clear_reg)
        begin
            seen_mem[clr_cnt_reg] <= '0;
        end
        else if (wr.en)
        begin
            seen_mem[wr.addr[ADDR_W-1:ROW_SEL_W]] <=
                row_q_reg | (ROW_W'(1) << wr.addr[ROW_SEL_W-1:0]);
        end
    end

    assign rdata.seen = row_q_reg[bit_q_reg];
    assign rdata.high = env_q_reg[2*VALUE_W-1:VALUE_W];
    assign rdata.low  = env_q_reg[VALUE_W-1:0];
    assign busy       = clear_reg;

    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> ($past(rd.en) && ($past(rd.addr) == wr.addr)))
        else $error("write not preceded by a read of the same entry");

    a_no_access_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear_reg |-> (!rd.en && !wr.en))
        else $error("access during clearing pass");

    a_clear_full: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clear_reg) |-> ($past(clr_cnt_reg) == '1))
        else $error("clearing pass ended early");

endmodule

// ===== hw/rtl/bucketed_min_max_envelope_core.sv =====
// Min/max envelope builder for up to eight signals over a shared time axis.
// Samples enter as beats on the in_valid/in_ready channel; each beat gives
// exactly one result beat on out_valid/out_ready, in order. Configuration is
// written through cfg_wr_en/cfg_index/cfg_data; the user must write it only
// while no sample is in flight, as the block itself does not enforce this.
// A sample that is disabled or lies outside the plot or session window goes
// from S_CHECK straight to S_DONE. For a binned sample the bucket number comes
// from an 11-step restoring divider of the window offset, then one read and
// one write of the envelope store (a cell memory plus a packed seen-flag
// memory). A bucket past the range gives ST_RANGE once the divider is done;
// when the offset is far beyond it, the divider skips its iterations.
// One sample is worked on at a time; the next beat is taken the cycle after
// the result has moved to the output register.
// After reset the seen flags are cleared in a pass over every seen row, during
// which in_ready stays low; configuration writes are taken throughout.
// When the receiver stalls, the finished result waits in the output register,
// a new sample may still be accepted and processed, and its result is held
// internally until the output register frees up.
module bucketed_min_max_envelope_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [bme_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [bme_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [bme_pkg::SIG_W-1:0]             signal,
    input  logic [bme_pkg::SRC_W-1:0]             source,
    input  logic [bme_pkg::TIME_W-1:0]            sample_time,
    input  logic signed [bme_pkg::VALUE_W-1:0]    sample_value,
    input  logic [bme_pkg::TIME_W-1:0]            session_start_ms,
    input  logic [bme_pkg::TIME_W-1:0]            session_end_ms,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [bme_pkg::STATUS_W-1:0]          status,
    output logic [bme_pkg::BUCKET_W-1:0]          bucket_index,
    output logic signed [bme_pkg::VALUE_W-1:0]    cell_min,
    output logic signed [bme_pkg::VALUE_W-1:0]    cell_max,
    output logic signed [bme_pkg::SUM_W-1:0]      pressure_total,
    output logic [bme_pkg::CNT_W-1:0]             pressure_count,
    output logic signed [bme_pkg::SUM_W-1:0]      leak_total,
    output logic [bme_pkg::CNT_W-1:0]             leak_count
);
    import bme_pkg::*;

    localparam int PROD_W = VALUE_W + 7;
    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(VAL_MAX);
    localparam logic signed [PROD_W-1:0] SAT_LO = PROD_W'(VAL_MIN);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CHECK  = 5'b00010,
        S_DIVIDE = 5'b00100,
        S_UPDATE = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Configuration.
    logic [TIME_W-1:0]      plot_start_reg, plot_end_reg;
    logic [WIDTH_W-1:0]     bucket_width_reg;
    logic [CELLS_CFG_W-1:0] cells_reg;
    logic [MASK_W-1:0]      mask_reg;
    logic [SRC_W-1:0]       flow_src_reg, leak_src_reg;

    // Captured sample.
    logic [SIG_W-1:0]          sig_reg, sig_next;
    logic [SRC_W-1:0]          src_reg, src_next;
    logic [TIME_W-1:0]         ts_reg, ts_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic [TIME_W-1:0]         ss_reg, ss_next;
    logic [TIME_W-1:0]         se_reg, se_next;
    logic signed [VALUE_W-1:0] scaled_reg, scaled_next;
    logic [ADDR_W-1:0]         idx_reg, idx_next;

    // Pending result.
    status_t                   res_status_reg, res_status_next;
    logic [BUCKET_W-1:0]       res_bucket_reg, res_bucket_next;
    logic signed [VALUE_W-1:0] res_min_reg, res_min_next;
    logic signed [VALUE_W-1:0] res_max_reg, res_max_next;

    // Running totals.
    logic signed [SUM_W-1:0] p_sum_reg, p_sum_next;
    logic [CNT_W-1:0]        p_cnt_reg, p_cnt_next;
    logic signed [SUM_W-1:0] l_sum_reg, l_sum_next;
    logic [CNT_W-1:0]        l_cnt_reg, l_cnt_next;

    // Output register.
    logic                      out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]       out_status_reg, out_status_next;
    logic [BUCKET_W-1:0]       out_bucket_reg, out_bucket_next;
    logic signed [VALUE_W-1:0] out_min_reg, out_min_next;
    logic signed [VALUE_W-1:0] out_max_reg, out_max_next;
    logic signed [SUM_W-1:0]   out_psum_reg, out_psum_next;
    logic [CNT_W-1:0]          out_pcnt_reg, out_pcnt_next;
    logic signed [SUM_W-1:0]   out_lsum_reg, out_lsum_next;
    logic [CNT_W-1:0]          out_lcnt_reg, out_lcnt_next;

    status_t                   chk_status;
    logic [TIME_W-1:0]         offset;
    logic                      boost;
    logic signed [PROD_W-1:0]  val_wide, product;
    logic signed [VALUE_W-1:0] scaled;
    logic [CELLS_CFG_W-1:0]    limit;
    logic [ADDR_W-1:0]         idx_calc;
    logic signed [VALUE_W-1:0] new_lo, new_hi;
    logic signed [SUM_W-1:0]   scaled_ext;

    logic                      div_start;
    div_res_t                  div_res;
    store_rd_t                 st_rd;
    store_wr_t                 st_wr;
    store_rdata_t              st_rdata;
    logic                      st_busy;

    bme_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (offset),
        .divisor  (bucket_width_reg),
        .result   (div_res)
    );

    bme_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .rd    (st_rd),
        .wr    (st_wr),
        .rdata (st_rdata),
        .busy  (st_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plot_start_reg   <= '0;
            plot_end_reg     <= '0;
            bucket_width_reg <= WIDTH_W'(1);
            cells_reg        <= CELLS_CFG_W'(CELLS);
            mask_reg         <= '0;
            flow_src_reg     <= '0;
            leak_src_reg     <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_PLOT_START: plot_start_reg   <= cfg_data[TIME_W-1:0];
                CFG_PLOT_END:   plot_end_reg     <= cfg_data[TIME_W-1:0];
                CFG_BUCKET_W:   bucket_width_reg <= cfg_data[WIDTH_W-1:0];
                CFG_CELLS:      cells_reg        <= cfg_data[CELLS_CFG_W-1:0];
                CFG_MASK:       mask_reg         <= cfg_data[MASK_W-1:0];
                CFG_FLOW_SRC:   flow_src_reg     <= cfg_data[SRC_W-1:0];
                CFG_LEAK_SRC:   leak_src_reg     <= cfg_data[SRC_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        // Window checks in their fixed priority order.
        if (({29'd0, sig_reg} >= 32'(SIGNALS)) || !mask_reg[sig_reg])
        begin
            chk_status = ST_DISABLED;
        end
        else if (ts_reg < plot_start_reg || ts_reg >= plot_end_reg)
        begin
            chk_status = ST_OUT_PLOT;
        end
        else if (ts_reg < ss_reg || ts_reg >= se_reg)
        begin
            chk_status = ST_OUT_SESSION;
        end
        else
        begin
            chk_status = ST_OK;
        end

        offset   = ts_reg - plot_start_reg;
        boost    = (sig_reg == SIG_W'(FLOW_ID) && src_reg == flow_src_reg) ||
                   (sig_reg == SIG_W'(LEAK_ID) && src_reg == leak_src_reg);
        val_wide = PROD_W'(val_reg);
        product  = boost ? val_wide * PROD_W'(SCALE) : val_wide;
        if (product > SAT_HI)
        begin
            scaled = VAL_MAX;
        end
        else if (product < SAT_LO)
        begin
            scaled = VAL_MIN;
        end
        else
        begin
            scaled = product[VALUE_W-1:0];
        end

        limit    = (cells_reg > CELLS_CFG_W'(CELLS)) ? CELLS_CFG_W'(CELLS) : cells_reg;
        idx_calc = ADDR_W'(sig_reg) * ADDR_W'(CELLS) + ADDR_W'(div_res.quotient);

        if (!st_rdata.seen)
        begin
            new_lo = scaled_reg;
            new_hi = scaled_reg;
        end
        else
        begin
            new_lo = (scaled_reg < st_rdata.low) ? scaled_reg : st_rdata.low;
            new_hi = (scaled_reg > st_rdata.high) ? scaled_reg : st_rdata.high;
        end
        scaled_ext = SUM_W'(scaled_reg);
    end

    always_comb
    begin
        state_next      = state_reg;
        sig_next        = sig_reg;
        src_next        = src_reg;
        ts_next         = ts_reg;
        val_next        = val_reg;
        ss_next         = ss_reg;
        se_next         = se_reg;
        scaled_next     = scaled_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_bucket_next = res_bucket_reg;
        res_min_next    = res_min_reg;
        res_max_next    = res_max_reg;
        p_sum_next      = p_sum_reg;
        p_cnt_next      = p_cnt_reg;
        l_sum_next      = l_sum_reg;
        l_cnt_next      = l_cnt_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_bucket_next = out_bucket_reg;
        out_min_next    = out_min_reg;
        out_max_next    = out_max_reg;
        out_psum_next   = out_psum_reg;
        out_pcnt_next   = out_pcnt_reg;
        out_lsum_next   = out_lsum_reg;
        out_lcnt_next   = out_lcnt_reg;
        div_start       = 1'b0;
        st_rd           = '0;
        st_wr           = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    sig_next   = signal;
                    src_next   = source;
                    ts_next    = sample_time;
                    val_next   = sample_value;
                    ss_next    = session_start_ms;
                    se_next    = session_end_ms;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                scaled_next = scaled;
                if (chk_status != ST_OK)
                begin
                    res_status_next = chk_status;
                    res_bucket_next = '0;
                    res_min_next    = '0;
                    res_max_next    = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIVIDE;
                end
            end
            S_DIVIDE:
            begin
                if (div_res.done)
                begin
                    if (div_res.over || div_res.quotient >= limit)
                    begin
                        res_status_next = ST_RANGE;
                        res_bucket_next = '0;
                        res_min_next    = '0;
                        res_max_next    = '0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        st_rd.en        = 1'b1;
                        st_rd.addr      = idx_calc;
                        idx_next        = idx_calc;
                        res_bucket_next = div_res.quotient[BUCKET_W-1:0];
                        state_next      = S_UPDATE;
                    end
                end
            end
            S_UPDATE:
            begin
                st_wr.en        = 1'b1;
                st_wr.addr      = idx_reg;
                st_wr.low       = new_lo;
                st_wr.high      = new_hi;
                res_status_next = ST_OK;
                res_min_next    = new_lo;
                res_max_next    = new_hi;
                // Pressure wins if both signal numbers were set equal.
                if (sig_reg == SIG_W'(PRESSURE_ID))
                begin
                    p_sum_next = p_sum_reg + scaled_ext;
                    if (p_cnt_reg != '1)
                    begin
                        p_cnt_next = p_cnt_reg + CNT_W'(1);
                    end
                end
                else if (sig_reg == SIG_W'(LEAK_ID))
                begin
                    l_sum_next = l_sum_reg + scaled_ext;
                    if (l_cnt_reg != '1)
                    begin
                        l_cnt_next = l_cnt_reg + CNT_W'(1);
                    end
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_bucket_next = res_bucket_reg;
                    out_min_next    = res_min_reg;
                    out_max_next    = res_max_reg;
                    out_psum_next   = p_sum_reg;
                    out_pcnt_next   = p_cnt_reg;
                    out_lsum_next   = l_sum_reg;
                    out_lcnt_next   = l_cnt_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            p_sum_reg     <= '0;
            p_cnt_reg     <= '0;
            l_sum_reg     <= '0;
            l_cnt_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            p_sum_reg     <= p_sum_next;
            p_cnt_reg     <= p_cnt_next;
            l_sum_reg     <= l_sum_next;
            l_cnt_reg     <= l_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sig_reg        <= sig_next;
        src_reg        <= src_next;
        ts_reg         <= ts_next;
        val_reg        <= val_next;
        ss_reg         <= ss_next;
        se_reg         <= se_next;
        scaled_reg     <= scaled_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_bucket_reg <= res_bucket_next;
        res_min_reg    <= res_min_next;
        res_max_reg    <= res_max_next;
        out_status_reg <= out_status_next;
        out_bucket_reg <= out_bucket_next;
        out_min_reg    <= out_min_next;
        out_max_reg    <= out_max_next;
        out_psum_reg   <= out_psum_next;
        out_pcnt_reg   <= out_pcnt_next;
        out_lsum_reg   <= out_lsum_next;
        out_lcnt_reg   <= out_lcnt_next;
    end

    assign in_ready       = (state_reg == S_IDLE) && !st_busy;
    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign bucket_index   = out_bucket_reg;
    assign cell_min       = out_min_reg;
    assign cell_max       = out_max_reg;
    assign pressure_total = out_psum_reg;
    assign pressure_count = out_pcnt_reg;
    assign leak_total     = out_lsum_reg;
    assign leak_count     = out_lcnt_reg;

    a_div_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (state_reg == S_DIVIDE))
        else $error("divider finished outside the divide phase");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |->
            (cell_min == '0 && cell_max == '0 && bucket_index == '0))
        else $error("rejected beat carries cell data");

    a_cell_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_OK) |-> (cell_min <= cell_max))
        else $error("cell minimum above maximum");

    a_update_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPDATE) |-> $past(st_rd.en))
        else $error("update without a preceding store read");

endmodule

// ===== bench/envelope_checker.sv =====
`timescale 1ns / 100ps

module envelope_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [bme_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [bme_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  in_valid,
    input  logic                                  in_ready,
    input  logic [bme_pkg::SIG_W-1:0]             signal,
    input  logic [bme_pkg::SRC_W-1:0]             source,
    input  logic [bme_pkg::TIME_W-1:0]            sample_time,
    input  logic signed [bme_pkg::VALUE_W-1:0]    sample_value,
    input  logic [bme_pkg::TIME_W-1:0]            session_start_ms,
    input  logic [bme_pkg::TIME_W-1:0]            session_end_ms,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  logic [bme_pkg::STATUS_W-1:0]          status,
    input  logic [bme_pkg::BUCKET_W-1:0]          bucket_index,
    input  logic signed [bme_pkg::VALUE_W-1:0]    cell_min,
    input  logic signed [bme_pkg::VALUE_W-1:0]    cell_max,
    input  logic signed [bme_pkg::SUM_W-1:0]      pressure_total,
    input  logic [bme_pkg::CNT_W-1:0]             pressure_count,
    input  logic signed [bme_pkg::SUM_W-1:0]      leak_total,
    input  logic [bme_pkg::CNT_W-1:0]             leak_count,
    output int unsigned                           fail_count,
    output int unsigned                           results_owed,
    output int unsigned                           binned_results
);
    import bme_pkg::*;

    typedef struct packed {
        status_t                   status;
        logic [BUCKET_W-1:0]       bucket;
        logic signed [VALUE_W-1:0] low;
        logic signed [VALUE_W-1:0] high;
        logic signed [SUM_W-1:0]   pressure_sum;
        logic [CNT_W-1:0]          pressure_n;
        logic signed [SUM_W-1:0]   leak_sum;
        logic [CNT_W-1:0]          leak_n;
    } cell_update_t;

    localparam int unsigned PRINT_CAP = 40;

    logic [TIME_W-1:0]       plot_start;
    logic [TIME_W-1:0]       plot_end;
    logic [WIDTH_W-1:0]      bucket_width;
    logic [CELLS_CFG_W-1:0]  cells_cfg;
    logic [MASK_W-1:0]       active_mask;
    logic [SRC_W-1:0]        flow_source;
    logic [SRC_W-1:0]        leak_source;

    logic signed [VALUE_W-1:0] env_low  [DEPTH];
    logic signed [VALUE_W-1:0] env_high [DEPTH];
    bit                        env_seen [DEPTH];
    logic signed [SUM_W-1:0]   pressure_sum;
    logic signed [SUM_W-1:0]   leak_sum;
    logic [CNT_W-1:0]          pressure_n;
    logic [CNT_W-1:0]          leak_n;

    cell_update_t predicted_updates [$];
    cell_update_t oldest;
    int unsigned  mismatches;
    int unsigned  results_checked;
    int unsigned  binned;

    // Applies one sample to the local copy of the envelope store and totals,
    // returning the result beat the block should produce for it.
    function automatic cell_update_t predict_envelope(
        input logic [SIG_W-1:0]          sig,
        input logic [SRC_W-1:0]          src,
        input logic [TIME_W-1:0]         ts,
        input logic signed [VALUE_W-1:0] val,
        input logic [TIME_W-1:0]         ss,
        input logic [TIME_W-1:0]         se
    );
        cell_update_t              r;
        longint unsigned           width_eff;
        longint unsigned           limit;
        longint unsigned           offset;
        longint unsigned           slot;
        longint                    scaled;
        logic signed [VALUE_W-1:0] v;
        logic [ADDR_W-1:0]         slot_addr;

        r.status = ST_OK;
        r.bucket = '0;
        r.low    = '0;
        r.high   = '0;
        if (sig >= SIGNALS || !active_mask[sig]) begin
            r.status = ST_DISABLED;
        end else if (ts < plot_start || ts >= plot_end) begin
            r.status = ST_OUT_PLOT;
        end else if (ts < ss || ts >= se) begin
            r.status = ST_OUT_SESSION;
        end else begin
            width_eff = (bucket_width == '0) ? 1 : bucket_width;
            limit     = (cells_cfg > CELLS) ? CELLS : cells_cfg;
            offset    = ts - plot_start;
            slot      = offset / width_eff;
            if (slot >= limit) begin
                r.status = ST_RANGE;
            end else begin
                scaled = longint'(val);
                if ((sig == FLOW_ID && src == flow_source) ||
                    (sig == LEAK_ID && src == leak_source))
                    scaled = scaled * SCALE;
                if (scaled > longint'(VAL_MAX))
                    scaled = longint'(VAL_MAX);
                else if (scaled < longint'(VAL_MIN))
                    scaled = longint'(VAL_MIN);
                v = scaled[VALUE_W-1:0];

                r.bucket  = slot[BUCKET_W-1:0];
                // CELLS is a power of two, so the store address is the signal
                // number stacked above the bucket number.
                slot_addr = {sig, r.bucket};
                if (!env_seen[slot_addr]) begin
                    env_seen[slot_addr] = 1'b1;
                    env_low[slot_addr]  = v;
                    env_high[slot_addr] = v;
                end else begin
                    if (v < env_low[slot_addr])
                        env_low[slot_addr] = v;
                    if (v > env_high[slot_addr])
                        env_high[slot_addr] = v;
                end
                r.low  = env_low[slot_addr];
                r.high = env_high[slot_addr];

                if (sig == PRESSURE_ID) begin
                    pressure_sum = pressure_sum + SUM_W'(v);
                    if (pressure_n != '1)
                        pressure_n = pressure_n + CNT_W'(1);
                end else if (sig == LEAK_ID) begin
                    leak_sum = leak_sum + SUM_W'(v);
                    if (leak_n != '1)
                        leak_n = leak_n + CNT_W'(1);
                end
            end
        end
        r.pressure_sum = pressure_sum;
        r.pressure_n   = pressure_n;
        r.leak_sum     = leak_sum;
        r.leak_n       = leak_n;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        else if (mismatches == PRINT_CAP + 1)
            $display("[%0t] further mismatches are counted but not printed", $realtime);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d: %s is %h, expected %h",
                                      results_checked, name, got, want));
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            plot_start   = '0;
            plot_end     = '0;
            bucket_width = WIDTH_W'(1);
            cells_cfg    = CELLS_CFG_W'(CELLS);
            active_mask  = '0;
            flow_source  = '0;
            leak_source  = '0;
            env_seen     = '{default: 1'b0};
            pressure_sum = '0;
            pressure_n   = '0;
            leak_sum     = '0;
            leak_n       = '0;
            predicted_updates.delete();
            mismatches      = 0;
            results_checked = 0;
            binned          = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_PLOT_START: plot_start   = cfg_data[TIME_W-1:0];
                    CFG_PLOT_END:   plot_end     = cfg_data[TIME_W-1:0];
                    CFG_BUCKET_W:   bucket_width = cfg_data[WIDTH_W-1:0];
                    CFG_CELLS:      cells_cfg    = cfg_data[CELLS_CFG_W-1:0];
                    CFG_MASK:       active_mask  = cfg_data[MASK_W-1:0];
                    CFG_FLOW_SRC:   flow_source  = cfg_data[SRC_W-1:0];
                    CFG_LEAK_SRC:   leak_source  = cfg_data[SRC_W-1:0];
                    default: ;
                endcase
            end

            // Retire the output beat before queueing a new sample so that a
            // stray result can never be matched against this cycle's input.
            if (out_valid && out_ready) begin
                if (predicted_updates.size() == 0) begin
                    report_mismatch($sformatf("result beat %0d arrived with no sample outstanding",
                                              results_checked));
                end else begin
                    oldest = predicted_updates.pop_front();
                    check_field("status", 64'(status), 64'(oldest.status));
                    check_field("bucket_index", 64'(bucket_index), 64'(oldest.bucket));
                    check_field("cell_min", 64'(cell_min), 64'(oldest.low));
                    check_field("cell_max", 64'(cell_max), 64'(oldest.high));
                    check_field("pressure_total", 64'(pressure_total),
                                64'(oldest.pressure_sum));
                    check_field("pressure_count", 64'(pressure_count),
                                64'(oldest.pressure_n));
                    check_field("leak_total", 64'(leak_total), 64'(oldest.leak_sum));
                    check_field("leak_count", 64'(leak_count), 64'(oldest.leak_n));
                    if (oldest.status == ST_OK)
                        binned++;
                end
                results_checked++;
            end

            if (in_valid && in_ready)
                predicted_updates.push_back(predict_envelope(signal, source, sample_time,
                                                             sample_value, session_start_ms,
                                                             session_end_ms));
        end
        results_owed   <= predicted_updates.size();
        fail_count     <= mismatches;
        binned_results <= binned;
    end

endmodule

// ===== bench/bucketed_min_max_envelope_core_test.sv =====
`timescale 1ns / 100ps

module bucketed_min_max_envelope_core_test;
    import bme_pkg::*;

    localparam logic [TIME_W-1:0] TIME_MAX    = '1;
    localparam int unsigned       STALL_LIMIT = 2000;
    localparam int unsigned       ROUNDS      = 12;
    localparam int unsigned       ROUND_BEATS = 155;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_wr_en;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;
    logic                        in_valid;
    logic                        in_ready;
    logic [SIG_W-1:0]            signal;
    logic [SRC_W-1:0]            source;
    logic [TIME_W-1:0]           sample_time;
    logic signed [VALUE_W-1:0]   sample_value;
    logic [TIME_W-1:0]           session_start_ms;
    logic [TIME_W-1:0]           session_end_ms;
    logic                        out_valid;
    logic                        out_ready;
    logic [STATUS_W-1:0]         status;
    logic [BUCKET_W-1:0]         bucket_index;
    logic signed [VALUE_W-1:0]   cell_min;
    logic signed [VALUE_W-1:0]   cell_max;
    logic signed [SUM_W-1:0]     pressure_total;
    logic [CNT_W-1:0]            pressure_count;
    logic signed [SUM_W-1:0]     leak_total;
    logic [CNT_W-1:0]            leak_count;

    int unsigned fail_count;
    int unsigned results_owed;
    int unsigned binned_results;

    bit          throttle;
    int unsigned samples_sent;
    int unsigned setups_written;

    bucketed_min_max_envelope_core i_dut (.*);

    envelope_checker i_checker (.*);

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic logic [TIME_W-1:0] rand_time();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[TIME_W-1:0];
    endfunction

    // Mostly short pauses, now and then a long one.
    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(12, 60);
        return $urandom_range(1, 3);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic apply_setup(input logic [TIME_W-1:0] start, input logic [TIME_W-1:0] stop,
                               input logic [WIDTH_W-1:0] width,
                               input logic [CELLS_CFG_W-1:0] cells,
                               input logic [MASK_W-1:0] mask, input logic [SRC_W-1:0] flow,
                               input logic [SRC_W-1:0] leak);
        write_reg(CFG_PLOT_START, CFG_DATA_W'(start));
        write_reg(CFG_PLOT_END, CFG_DATA_W'(stop));
        write_reg(CFG_BUCKET_W, CFG_DATA_W'(width));
        write_reg(CFG_CELLS, CFG_DATA_W'(cells));
        write_reg(CFG_MASK, CFG_DATA_W'(mask));
        write_reg(CFG_FLOW_SRC, CFG_DATA_W'(flow));
        write_reg(CFG_LEAK_SRC, CFG_DATA_W'(leak));
        cfg_wr_en <= 1'b0;
        setups_written++;
    endtask

    // Presents one sample beat and returns at the edge where it is taken,
    // leaving valid high so a back-to-back beat needs no extra cycle.
    task automatic send_sample(input logic [SIG_W-1:0] sig, input logic [SRC_W-1:0] src,
                               input logic [TIME_W-1:0] ts,
                               input logic signed [VALUE_W-1:0] val,
                               input logic [TIME_W-1:0] ss, input logic [TIME_W-1:0] se);
        int unsigned gap;
        gap = (throttle && $urandom_range(0, 1) == 1) ? pick_gap() : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1'b1;
        signal           <= sig;
        source           <= src;
        sample_time      <= ts;
        sample_value     <= val;
        session_start_ms <= ss;
        session_end_ms   <= se;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        samples_sent++;
    endtask

    task automatic drain_and_settle(input int unsigned settle);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (results_owed != 0);
        repeat (settle) @(posedge clk);
    endtask

    // Result side: random back-pressure while throttled; otherwise ready once any stall in progress ends.
    initial begin
        int unsigned hold;
        hold      = 0;
        out_ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold != 0) begin
                hold--;
            end else if (throttle && $urandom_range(0, 2) == 0) begin
                out_ready <= 1'b0;
                hold = pick_gap() - 1;
            end else begin
                out_ready <= 1'b1;
                hold = throttle ? $urandom_range(0, 4) : 0;
            end
        end
    end

    initial begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("no beat moved for %0d cycles, %0d results still owed",
                 STALL_LIMIT, results_owed);
        $display("bucketed_min_max_envelope_core regression: fail");
        $finish;
    end

    initial begin
        longint unsigned           start;
        longint unsigned           stop;
        longint unsigned           width_eff;
        longint unsigned           cells_eff;
        longint unsigned           span;
        longint unsigned           slot;
        longint unsigned           stamp;
        longint unsigned           lead;
        longint unsigned           tail;
        logic [WIDTH_W-1:0]        width;
        logic [CELLS_CFG_W-1:0]    cells;
        logic [SIG_W-1:0]          sig;
        logic [SRC_W-1:0]          src;
        logic [TIME_W-1:0]         ts;
        logic [TIME_W-1:0]         ss;
        logic [TIME_W-1:0]         se;
        logic signed [VALUE_W-1:0] val;

        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        in_valid         = 1'b0;
        signal           = '0;
        source           = '0;
        sample_time      = '0;
        sample_value     = '0;
        session_start_ms = '0;
        session_end_ms   = '0;
        throttle         = 1'b1;
        samples_sent     = 0;
        setups_written   = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Out of reset no signal is enabled.
        send_sample(0, 0, 0, 0, 0, TIME_MAX);
        send_sample(7, 8'hFF, TIME_MAX, VAL_MIN, 0, TIME_MAX);
        drain_and_settle(4);

        // Window 1000..2000 in 10 ms buckets, 64 buckets, signal 3 masked off.
        apply_setup(1000, 2000, 10, 64, 8'hF7, 5, 7);
        send_sample(3, 5, 1500, 42, 0, TIME_MAX);
        send_sample(0, 5, 999, 1, 0, TIME_MAX);
        send_sample(0, 5, 2000, 1, 0, TIME_MAX);
        send_sample(0, 5, 1000, 1000, 0, TIME_MAX);
        send_sample(0, 4, 1009, -5, 0, TIME_MAX);
        send_sample(0, 5, 1005, VAL_MAX, 0, TIME_MAX);
        send_sample(0, 5, 1001, VAL_MIN, 0, TIME_MAX);
        send_sample(1, 7, 1010, -7, 0, TIME_MAX);
        send_sample(1, 5, 1011, 123, 0, TIME_MAX);
        send_sample(2, 5, 1020, 77, 0, TIME_MAX);
        send_sample(2, 0, 1020, VAL_MIN, 0, TIME_MAX);
        send_sample(4, 9, 1500, 3, 1501, TIME_MAX);
        send_sample(4, 9, 1500, 3, 0, 1500);
        send_sample(4, 9, 1500, 3, 1500, 1501);
        send_sample(4, 9, 1500, 3, 1600, 1400);
        send_sample(5, 0, 1640, 8, 0, TIME_MAX);
        send_sample(5, 0, 1639, -8, 0, TIME_MAX);
        drain_and_settle(4);

        // Zero width acts as 1 ms; zero cells puts every sample out of range.
        apply_setup(0, TIME_MAX, 0, 0, 8'hFF, 8'hFF, 8'hFF);
        send_sample(6, 1, 0, 5, 0, TIME_MAX);
        drain_and_settle(4);

        // Widest buckets, cell count above the store size.
        apply_setup(0, TIME_MAX, '1, '1, 8'hFF, 8'hFF, 8'hFF);
        send_sample(7, 3, TIME_MAX - 1, 9, 0, TIME_MAX);
        send_sample(7, 3, 48'd1023 * 48'hFFFF_FFFF, VAL_MAX, 0, TIME_MAX);
        send_sample(0, 8'hFF, 5, -32'sd40000000, 0, TIME_MAX);
        send_sample(1, 8'hFF, 6, 32'sd40000000, 0, TIME_MAX);
        drain_and_settle(4);

        // Inverted plot window at the top of the time range.
        apply_setup(TIME_MAX, 5, 1, 1, 8'h00, 8'h00, 8'h00);
        send_sample(2, 0, TIME_MAX, 1, 0, TIME_MAX);

        for (int unsigned round = 0; round < ROUNDS; round++) begin
            drain_and_settle(4);
            throttle <= (round % 3) != 2;

            case ($urandom_range(0, 4))
                0:       width = '0;
                1:       width = $urandom_range(0, 1) ? '1 : WIDTH_W'($urandom);
                default: width = WIDTH_W'($urandom_range(1, 40));
            endcase
            case ($urandom_range(0, 5))
                0:       cells = CELLS_CFG_W'($urandom_range(CELLS + 1, 2047));
                1:       cells = CELLS_CFG_W'(CELLS);
                default: cells = CELLS_CFG_W'($urandom_range(1, 48));
            endcase
            width_eff = (width == '0) ? 1 : width;
            cells_eff = (cells > CELLS) ? CELLS : cells;
            span      = width_eff * cells_eff;
            case ($urandom_range(0, 9))
                0:       start = rand_time();
                1:       start = TIME_MAX - span - $urandom_range(0, 500);
                default: start = $urandom_range(0, 100000);
            endcase
            // A quarter of the settings cut the window short of the last bucket.
            if ($urandom_range(0, 3) == 0)
                stop = start + span / 2;
            else
                stop = start + span + $urandom_range(0, 1000);
            if (stop > TIME_MAX)
                stop = TIME_MAX;
            apply_setup(TIME_W'(start), TIME_W'(stop), width, cells,
                        ($urandom_range(0, 3) == 0) ? 8'hFF : MASK_W'($urandom | $urandom),
                        ($urandom_range(0, 4) == 0) ? SRC_W'($urandom)
                                                    : SRC_W'($urandom_range(0, 3)),
                        ($urandom_range(0, 4) == 0) ? SRC_W'($urandom)
                                                    : SRC_W'($urandom_range(0, 3)));

            repeat (ROUND_BEATS) begin
                if ($urandom_range(0, 4) == 0) begin
                    sig = SIG_W'($urandom_range(0, 7));
                    src = SRC_W'($urandom);
                    ts  = rand_time();
                    val = $urandom;
                    ss  = rand_time();
                    se  = rand_time();
                end else begin
                    // Well-formed sample, mostly on the few channels that carry
                    // scaling and totals, often revisiting the first buckets.
                    sig = $urandom_range(0, 1) ? SIG_W'($urandom_range(0, 2))
                                               : SIG_W'($urandom_range(0, 7));
                    src = ($urandom_range(0, 3) == 0) ? SRC_W'($urandom)
                                                      : SRC_W'($urandom_range(0, 3));
                    case ($urandom_range(0, 9))
                        0:          slot = cells_eff;
                        1, 2, 3, 4: slot = $urandom_range(0, 32'((cells_eff < 4) ?
                                                                 cells_eff - 1 : 3));
                        default:    slot = $urandom_range(0, 32'(cells_eff - 1));
                    endcase
                    stamp = start + slot * width_eff + $urandom_range(0, 32'(width_eff - 1));
                    if (stamp > TIME_MAX)
                        stamp = TIME_MAX;
                    ts = TIME_W'(stamp);
                    case ($urandom_range(0, 7))
                        0:       val = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
                        1:       val = $urandom;
                        2:       val = $urandom_range(0, 80000000) - 40000000;
                        default: val = $urandom_range(0, 200000) - 100000;
                    endcase
                    lead = $urandom_range(0, 5000);
                    tail = stamp + 1 + $urandom_range(0, 5000);
                    case ($urandom_range(0, 9))
                        0: begin
                            ss = TIME_W'(stamp + 1);
                            se = TIME_MAX;
                        end
                        1: begin
                            ss = '0;
                            se = ts;
                        end
                        2: begin
                            ss = rand_time();
                            se = rand_time();
                        end
                        default: begin
                            ss = (stamp > lead) ? TIME_W'(stamp - lead) : '0;
                            se = (tail > TIME_MAX) ? TIME_MAX : TIME_W'(tail);
                        end
                    endcase
                end
                send_sample(sig, src, ts, val, ss, se);
            end
        end

        drain_and_settle(30);
        $display("%0d samples under %0d register settings, %0d of them binned;",
                 samples_sent, setups_written, binned_results);
        $display("the rest were disabled, off-window, off-session or past the last bucket.");
        if (fail_count == 0)
            $display("bucketed_min_max_envelope_core regression: pass");
        else
            $display("bucketed_min_max_envelope_core regression: fail");
        $finish;
    end

endmodule
